// File: rtl/indexed_list_engine_defines.svh
// Assertion macros used by the checker file.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Checked only while the block is out of reset.
`define ILE_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ILE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ile_pkg.sv
package ile_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CMD_W     = 3;
  localparam int VAL_W     = 32;
  localparam int POS_IN_W  = 5;
  localparam int POS_OUT_W = 4;
  localparam int STAT_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_POP    = 3'd3,
    CMD_DELETE = 3'd4,
    CMD_DUMP   = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  typedef struct packed {
    logic accept;
    logic dump_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic dump_enter;
    logic dump_last;
  } dp_stat_t;

endpackage

// File: rtl/ile_if.sv
interface ile_in_if;
  logic                                valid;
  logic                                ready;
  logic [ile_pkg::CMD_W-1:0]           cmd;
  logic signed [ile_pkg::VAL_W-1:0]    item_value;
  logic [ile_pkg::POS_IN_W-1:0]        position_in;

  modport source(output valid, cmd, item_value, position_in, input ready);
  modport sink(input valid, cmd, item_value, position_in, output ready);
endinterface

interface ile_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ile_pkg::VAL_W-1:0]    read_value;
  logic [ile_pkg::POS_OUT_W-1:0]       read_position;
  logic                                last_flag;
  logic [ile_pkg::STAT_W-1:0]          status;

  modport source(output valid, read_value, read_position, last_flag, status, input ready);
  modport sink(input valid, read_value, read_position, last_flag, status, output ready);
endinterface

// File: rtl/indexed_list_engine.sv
// Ordered list of up to DEPTH signed 32-bit values, position 0 at the front.
// Requests arrive on in_ch (valid/ready); each carries a command, a value and
// a position. Results leave on out_res (valid/ready) from an output register.
// An edit (push, append, insert, pop, delete) is applied in the cycle its
// request is taken and its single status result is valid on the next cycle,
// so edits sustain one request per cycle while the receiver keeps up.
// A dump returns one result per stored entry, front first, one per cycle
// while the receiver keeps up, with last_flag set on the final one; every
// result is read from the front entry while the entry array rotates by one
// place. The request is first registered as the dump state, and from that
// state the first result is loaded into the output register; no request is
// taken until the last one is loaded. A dump of an empty list gives a single
// result with the empty status on the next cycle. Failed edits return their
// status and leave the list unchanged.
// When the receiver stalls, the output register holds its result and a new
// request is taken only once that result is being taken.
// Reset empties the list at once; stored values are not cleared.
module indexed_list_engine #(
  parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  ile_in_if.sink   in_ch,
  ile_out_if.source out_res
);

  ile_pkg::ctl_cmd_t ctl;
  ile_pkg::dp_stat_t stat;

  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_res.ready),
    .out_valid (out_res.valid),
    .stat      (stat),
    .ctl       (ctl)
  );

  ile_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .stat              (stat),
    .in_cmd            (in_ch.cmd),
    .in_item_value     (in_ch.item_value),
    .in_position       (in_ch.position_in),
    .out_read_value    (out_res.read_value),
    .out_read_position (out_res.read_position),
    .out_last_flag     (out_res.last_flag),
    .out_status        (out_res.status)
  );

endmodule

// File: rtl/ile_ctrl.sv
module ile_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  ile_pkg::dp_stat_t stat,
  output ile_pkg::ctl_cmd_t ctl
);

  ile_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ile_pkg::ST_IDLE: begin
        if (in_valid && slot_free && stat.dump_enter) begin
          state_nxt = ile_pkg::ST_DUMP;
        end
      end
      ile_pkg::ST_DUMP: begin
        if (slot_free && stat.dump_last) begin
          state_nxt = ile_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ile_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ile_pkg::ST_IDLE) && slot_free;
    ctl.accept    = in_valid && in_ready;
    ctl.dump_step = (state_r == ile_pkg::ST_DUMP) && slot_free;
    if ((ctl.accept && !stat.dump_enter) || ctl.dump_step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ile_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/ile_datapath.sv
module ile_datapath #(
  parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ile_pkg::ctl_cmd_t                   ctl,
  output ile_pkg::dp_stat_t                   stat,
  input  logic [ile_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [ile_pkg::VAL_W-1:0]    in_item_value,
  input  logic [ile_pkg::POS_IN_W-1:0]        in_position,
  output logic signed [ile_pkg::VAL_W-1:0]    out_read_value,
  output logic [ile_pkg::POS_OUT_W-1:0]       out_read_position,
  output logic                                out_last_flag,
  output logic [ile_pkg::STAT_W-1:0]          out_status
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > ile_pkg::POS_IN_W) ? CNT_W : ile_pkg::POS_IN_W;

  logic signed [ile_pkg::VAL_W-1:0] ent_r   [DEPTH];
  logic signed [ile_pkg::VAL_W-1:0] ent_nxt [DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] dump_idx_r, dump_idx_nxt;

  logic signed [ile_pkg::VAL_W-1:0] value_r, value_nxt;
  logic [ile_pkg::POS_OUT_W-1:0]    rpos_r, rpos_nxt;
  logic                             last_r, last_nxt;
  ile_pkg::status_t                 status_r, status_nxt;

  logic [CMP_W-1:0] cnt_x, pos_x, last_x, edit_pos;
  logic             full, empty, do_ins, do_rem, ins_en, rem_en, dump_last;
  ile_pkg::status_t edit_status;

  assign cnt_x  = CMP_W'(count_r);
  assign pos_x  = CMP_W'(in_position);
  assign last_x = cnt_x - CMP_W'(1);
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  always_comb begin
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    edit_pos    = '0;
    edit_status = ile_pkg::STAT_OK;
    case (in_cmd)
      ile_pkg::CMD_PUSH: begin
        if (full) edit_status = ile_pkg::STAT_FULL;
        else      do_ins      = 1'b1;
      end
      ile_pkg::CMD_APPEND: begin
        edit_pos = cnt_x;
        priority if (empty) edit_status = ile_pkg::STAT_EMPTY;
        else if (full)      edit_status = ile_pkg::STAT_FULL;
        else                do_ins      = 1'b1;
      end
      ile_pkg::CMD_INSERT: begin
        edit_pos = pos_x;
        priority if (full)     edit_status = ile_pkg::STAT_FULL;
        else if (pos_x > cnt_x) edit_status = ile_pkg::STAT_RANGE;
        else                   do_ins      = 1'b1;
      end
      ile_pkg::CMD_POP: begin
        if (empty) edit_status = ile_pkg::STAT_EMPTY;
        else       do_rem      = 1'b1;
      end
      ile_pkg::CMD_DELETE: begin
        edit_pos = pos_x;
        priority if (empty)     edit_status = ile_pkg::STAT_EMPTY;
        else if (pos_x >= cnt_x) edit_status = ile_pkg::STAT_RANGE;
        else                    do_rem      = 1'b1;
      end
      ile_pkg::CMD_DUMP: begin
        if (empty) edit_status = ile_pkg::STAT_EMPTY;
      end
      default: edit_status = ile_pkg::STAT_OK;
    endcase
  end

  assign ins_en    = ctl.accept && do_ins;
  assign rem_en    = ctl.accept && do_rem;
  assign dump_last = ((CNT_W'(dump_idx_r) + CNT_W'(1)) == count_r);

  assign stat.dump_enter = (in_cmd == ile_pkg::CMD_DUMP) && !empty;
  assign stat.dump_last  = dump_last;

  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    localparam logic [CMP_W-1:0] GI = CMP_W'(g);
    logic signed [ile_pkg::VAL_W-1:0] prev_v, next_v;

    if (g > 0) begin : g_prev
      assign prev_v = ent_r[g-1];
    end else begin : g_first
      assign prev_v = ent_r[g];
    end

    if (g < DEPTH - 1) begin : g_next
      assign next_v = ent_r[g+1];
    end else begin : g_tail
      assign next_v = ent_r[g];
    end

    always_comb begin
      ent_nxt[g] = ent_r[g];
      if (ins_en) begin
        if (GI == edit_pos) begin
          ent_nxt[g] = in_item_value;
        end else if (GI > edit_pos) begin
          ent_nxt[g] = prev_v;
        end
      end else if (rem_en) begin
        if (GI >= edit_pos) begin
          ent_nxt[g] = next_v;
        end
      end else if (ctl.dump_step) begin
        if (GI == last_x) begin
          ent_nxt[g] = ent_r[0];
        end else begin
          ent_nxt[g] = next_v;
        end
      end
    end

    always_ff @(posedge clk) begin
      ent_r[g] <= ent_nxt[g];
    end
  end

  always_comb begin
    count_nxt    = count_r;
    dump_idx_nxt = dump_idx_r;
    if (ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rem_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (ctl.accept) begin
      dump_idx_nxt = '0;
    end else if (ctl.dump_step) begin
      dump_idx_nxt = dump_idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    value_nxt  = value_r;
    rpos_nxt   = rpos_r;
    last_nxt   = last_r;
    status_nxt = status_r;
    if (ctl.dump_step) begin
      value_nxt  = ent_r[0];
      rpos_nxt   = ile_pkg::POS_OUT_W'(dump_idx_r);
      last_nxt   = dump_last;
      status_nxt = ile_pkg::STAT_OK;
    end else if (ctl.accept) begin
      value_nxt  = '0;
      rpos_nxt   = '0;
      last_nxt   = !stat.dump_enter;
      status_nxt = edit_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      dump_idx_r <= '0;
    end else begin
      count_r    <= count_nxt;
      dump_idx_r <= dump_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    rpos_r   <= rpos_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
  end

  assign out_read_value    = value_r;
  assign out_read_position = rpos_r;
  assign out_last_flag     = last_r;
  assign out_status        = status_r;

endmodule

// File: rtl/ile_checker.sv
`include "indexed_list_engine_defines.svh"

module ile_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [ile_pkg::VAL_W-1:0] out_read_value,
  input logic [ile_pkg::POS_OUT_W-1:0]    out_read_position,
  input logic                             out_last_flag,
  input logic [ile_pkg::STAT_W-1:0]       out_status
);

  `ILE_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "Result valid after reset")
  `ILE_ASSERT_RUN(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(out_read_value) && $stable(out_read_position) && $stable(out_last_flag) && $stable(out_status), "Stalled result changed")
  `ILE_ASSERT_RUN(a_mid_dump_ok, out_valid && !out_last_flag |-> out_status == ile_pkg::STAT_OK, "Non-final result without ok status")
  `ILE_ASSERT_RUN(a_no_request_mid_dump, out_valid && !out_last_flag |-> !in_ready, "Request taken during a dump")

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_res.valid),
  .out_ready         (out_res.ready),
  .out_read_value    (out_res.read_value),
  .out_read_position (out_res.read_position),
  .out_last_flag     (out_res.last_flag),
  .out_status        (out_res.status)
);
